// ===== src/slist_pkg.sv =====
package slist_pkg;

   localparam int unsigned CAPACITY_DEF = 16;
   localparam int unsigned VALUE_W      = 32;
   localparam int unsigned POS_W        = 4;
   // entry_value and position, padded to whole bytes
   localparam int unsigned RSP_TDATA_W  = ((VALUE_W + POS_W + 7) / 8) * 8;

endpackage

// ===== src/sorted_list_insert.sv =====
// Channel   Dir  Handshake              Payload
// req_      in   req_tvalid/req_tready  tdata: value
// rsp_      out  rsp_tvalid/rsp_tready  tdata: entry_value, position; tlast; tuser: dropped
//
// An item is first accepted, which starts the first memory read; then, while the result side
// does not stall, one result per cycle follows, one per entry that the list then holds, each
// paced by the registered read of the entry store feeding a read-modify-write pass.
// The next item is accepted once the last result is in the output register.
// Reset (synchronous, active high) empties the list; the entry store is not cleared.
// A stalled result holds the output register and freezes the pass in place.
module sorted_list_insert #(
   parameter int unsigned CAPACITY = slist_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [slist_pkg::VALUE_W-1:0]      req_tdata,  // [31:0] value
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [slist_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // [31:0] entry_value, [35:32] position
   output logic                               rsp_tlast,  // last
   output logic                               rsp_tuser   // dropped
);

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned VW = slist_pkg::VALUE_W;
   localparam int unsigned PW = slist_pkg::POS_W;
   localparam int unsigned DW = slist_pkg::RSP_TDATA_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic                 state_ff, state_in;
   logic [CW-1:0]        occ_ff, occ_in;
   logic [CW-1:0]        old_cnt_ff, old_cnt_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 drop_ff, drop_in;
   logic                 ins_ff, ins_in;
   logic signed [VW-1:0] val_ff, val_in;
   logic [VW-1:0]        carry_ff, carry_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]        rsp_value_ff, rsp_value_in;
   logic [PW-1:0]        rsp_pos_ff, rsp_pos_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_drop_ff, rsp_drop_in;

   logic [VW-1:0]        mem [CAPACITY];
   logic [VW-1:0]        rd_data_ff;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [VW-1:0]        wr_data;

   logic                 accept;
   logic                 out_free;
   logic                 step;
   logic                 old_valid;
   logic                 old_less;
   logic                 is_last;
   logic [CW-1:0]        idx_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = (state_ff == ST_EMIT) && out_free;
   assign old_valid  = idx_ff < old_cnt_ff;
   assign old_less   = $signed(rd_data_ff) < val_ff;
   assign idx_next   = idx_ff + CW'(1);
   assign is_last    = (idx_next == occ_ff);

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      old_cnt_in   = old_cnt_ff;
      idx_in       = idx_ff;
      drop_in      = drop_ff;
      ins_in       = ins_ff;
      val_in       = val_ff;
      carry_in     = carry_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_drop_in  = rsp_drop_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[AW-1:0];
      wr_data      = val_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         rd_en      = 1'b1;
         rd_addr    = '0;
         idx_in     = '0;
         old_cnt_in = occ_ff;
         drop_in    = (occ_ff == CW'(CAPACITY));
         ins_in     = 1'b0;
         val_in     = $signed(req_tdata);
         if (occ_ff != CW'(CAPACITY)) begin
            occ_in = occ_ff + CW'(1);
         end
         state_in = ST_EMIT;
      end

      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = PW'(idx_ff);
         rsp_last_in  = is_last;
         rsp_drop_in  = drop_ff;
         priority if (drop_ff) begin
            rsp_value_in = rd_data_ff;
         end else if (ins_ff) begin
            // ripple the displaced entry one place up
            rsp_value_in = carry_ff;
            wr_en        = 1'b1;
            wr_data      = carry_ff;
            carry_in     = rd_data_ff;
         end else if (!old_valid || !old_less) begin
            rsp_value_in = val_ff;
            wr_en        = 1'b1;
            wr_data      = val_ff;
            carry_in     = rd_data_ff;
            ins_in       = 1'b1;
         end else begin
            rsp_value_in = rd_data_ff;
         end
         if (is_last) begin
            state_in = ST_IDLE;
         end else begin
            idx_in  = idx_next;
            rd_en   = 1'b1;
            rd_addr = idx_next[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      old_cnt_ff   <= old_cnt_in;
      idx_ff       <= idx_in;
      drop_ff      <= drop_in;
      ins_ff       <= ins_in;
      val_ff       <= val_in;
      carry_ff     <= carry_in;
      rsp_value_ff <= rsp_value_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   // entry store: one write and one read per cycle, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DW'({rsp_pos_ff, rsp_value_ff});
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_drop_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(CAPACITY))
      else $error("occupancy beyond capacity");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> occ_ff == CW'(CAPACITY))
      else $error("dropped result with room in the list");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("new item taken during a listing");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> idx_ff < occ_ff)
      else $error("listing index past occupancy");

   a_no_write_on_drop: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !drop_ff)
      else $error("store written while dropping an item");

endmodule
